### rtl/mbap_pkg.sv
// Shared types and constants for the MBAP frame builder and checker.
`timescale 1ns / 1ps

package mbap_pkg;

  localparam int BUFFER_BYTES = 260;
  localparam int HDR_BYTES    = 8;
  localparam int PREFIX_BYTES = 6;
  localparam int MAX_PAYLOAD  = BUFFER_BYTES - HDR_BYTES;
  localparam int RX_MAX       = 511;
  localparam int RX_W         = 9;
  localparam int RUN_W        = $clog2(HDR_BYTES);
  localparam int EXC_BIT      = 7;

  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_SEND  = 2'd1,
    OP_RECV  = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_TX     = 2'd0,
    KIND_RX     = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ST_GOOD      = 4'd0,
    ST_BUSY      = 4'd1,
    ST_OVERFLOW  = 4'd2,
    ST_SHORT     = 4'd3,
    ST_PROTOCOL  = 4'd4,
    ST_LENGTH    = 4'd5,
    ST_ID        = 4'd6,
    ST_UNIT      = 4'd7,
    ST_EXC_MISS  = 4'd8,
    ST_FUNCTION  = 4'd9,
    ST_EXCEPTION = 4'd10
  } status_t;

  typedef enum logic [0:0] {
    REG_SERVER_MODE = 1'b0,
    REG_MAX_READ    = 1'b1
  } cfg_reg_t;

  typedef logic [HDR_BYTES-1:0][7:0] hdr_t;

  typedef struct packed {
    hdr_t            hdr;
    logic [RX_W-1:0] rx_count;
    logic [7:0]      first_byte;
    logic [15:0]     tid;
    logic [7:0]      unit;
    logic [7:0]      func;
    logic            server;
  } chk_in_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] exc;
  } chk_out_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] byte_out;
    logic       last;
    status_t    status;
    logic [7:0] exc;
    logic [7:0] ru;
    logic [7:0] rf;
    logic [7:0] cnt;
  } result_t;

endpackage

### rtl/mbap_if.sv
// Valid/ready channel interfaces for input items and result items.
`timescale 1ns / 1ps

interface mbap_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] unit_id;
  logic [7:0] function_code;
  logic [8:0] payload_length;
  logic       repeat_id;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source(output valid, opcode, unit_id, function_code, payload_length, repeat_id,
                 data_byte, frame_end, input ready);
  modport sink(input valid, opcode, unit_id, function_code, payload_length, repeat_id,
               data_byte, frame_end, output ready);
endinterface

interface mbap_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] byte_out;
  logic       last_of_run;
  logic [3:0] status;
  logic [7:0] exception_code;
  logic [7:0] resp_unit;
  logic [7:0] resp_function;
  logic [7:0] payload_count;

  modport source(output valid, kind, byte_out, last_of_run, status, exception_code,
                 resp_unit, resp_function, payload_count, input ready);
  modport sink(input valid, kind, byte_out, last_of_run, status, exception_code,
               resp_unit, resp_function, payload_count, output ready);
endinterface

### rtl/mbap_check.sv
// Received frame check: header fields against the request, final status.
`timescale 1ns / 1ps

module mbap_check import mbap_pkg::*; (
  input  chk_in_t  chk_in,
  output chk_out_t chk_out
);

  logic [15:0] len_field;
  logic [15:0] rx_id;
  logic [15:0] expect_len;

  assign len_field  = {chk_in.hdr[4], chk_in.hdr[5]};
  assign rx_id      = {chk_in.hdr[0], chk_in.hdr[1]};
  assign expect_len = {{(16 - RX_W){1'b0}}, chk_in.rx_count - RX_W'(PREFIX_BYTES)};

  always_comb begin
    chk_out.exc = '0;
    if (chk_in.rx_count < RX_W'(HDR_BYTES)) begin
      chk_out.status = ST_SHORT;
    end else if (chk_in.hdr[2] != 8'd0 || chk_in.hdr[3] != 8'd0) begin
      chk_out.status = ST_PROTOCOL;
    end else if (chk_in.rx_count >= RX_W'(RX_MAX) || len_field != expect_len) begin
      chk_out.status = ST_LENGTH;
    end else if (chk_in.server) begin
      chk_out.status = ST_GOOD;
    end else if (rx_id != chk_in.tid) begin
      chk_out.status = ST_ID;
    end else if (chk_in.hdr[6] != chk_in.unit) begin
      chk_out.status = ST_UNIT;
    end else if (chk_in.hdr[7][EXC_BIT]) begin
      if (chk_in.rx_count > RX_W'(HDR_BYTES)) begin
        chk_out.status = ST_EXCEPTION;
        chk_out.exc    = chk_in.first_byte;
      end else begin
        chk_out.status = ST_EXC_MISS;
      end
    end else if (chk_in.hdr[7] != chk_in.func) begin
      chk_out.status = ST_FUNCTION;
    end else begin
      chk_out.status = ST_GOOD;
    end
  end

endmodule

### rtl/mbap_frame_builder_checker.sv
// Modbus TCP MBAP frame builder and response checker, top level.
// The first result of an item is offered in the cycle after the item is accepted.
// One item per cycle while the result register is free or giving its last result;
// an item holds it until its results are taken (eight for a header, else zero to two).
// Reset (rst, synchronous): clears id, busy, receive counters and the result register;
// client mode, max_read_length 252. The received header bytes are not reset.
`timescale 1ns / 1ps

module mbap_frame_builder_checker import mbap_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [0:0]       cfg_index,
  input  logic [7:0]       cfg_data,
  mbap_in_if.sink          din,
  mbap_out_if.source       dout
);

  logic            server_mode;
  logic [7:0]      max_read_length;
  logic [15:0]     transaction_id, transaction_id_next;
  logic            busy, busy_next;
  logic [7:0]      pending_unit, pending_unit_next;
  logic [7:0]      pending_function, pending_function_next;
  hdr_t            header_store, header_store_next;
  logic [7:0]      first_data_byte, first_data_byte_next;
  logic [RX_W-1:0] rx_count, rx_count_next;
  logic [7:0]      delivered_count, delivered_count_next;

  logic            run_valid;
  logic            run_hdr;
  logic [RUN_W-1:0] run_len;
  logic [RUN_W-1:0] run_idx;
  hdr_t            run_bytes;
  result_t         run_res [2];

  logic            in_ready;
  logic            accept;
  logic            run_done;
  logic            load, load_hdr;
  logic [RUN_W-1:0] load_len;
  hdr_t            load_bytes;
  result_t         load_res [2];

  hdr_t            rx_hdr;
  logic [7:0]      rx_first;
  logic            rx_deliver;
  logic [7:0]      rx_dc;
  logic [RX_W-1:0] rx_cnt_new;
  chk_in_t         chk_in;
  chk_out_t        chk_out;
  result_t         cur;

  assign run_done = dout.valid && dout.ready && (run_idx == run_len);
  assign in_ready = !run_valid || run_done;
  assign din.ready = in_ready;
  assign accept = din.valid && in_ready;

  always_comb begin
    rx_hdr = header_store;
    if (rx_count < RX_W'(HDR_BYTES)) begin
      rx_hdr[rx_count[RUN_W-1:0]] = din.data_byte;
    end
    rx_first   = (rx_count == RX_W'(HDR_BYTES)) ? din.data_byte : first_data_byte;
    rx_deliver = (rx_count >= RX_W'(HDR_BYTES)) && (delivered_count < max_read_length);
    rx_dc      = delivered_count + 8'(rx_deliver);
    rx_cnt_new = (rx_count < RX_W'(RX_MAX)) ? rx_count + RX_W'(1) : rx_count;
  end

  assign chk_in = '{hdr: rx_hdr, rx_count: rx_cnt_new, first_byte: rx_first,
                    tid: transaction_id, unit: pending_unit, func: pending_function,
                    server: server_mode};

  mbap_check u_check (
    .chk_in  (chk_in),
    .chk_out (chk_out)
  );

  always_comb begin
    logic [15:0] tid_new;
    logic [15:0] cbytes;
    result_t     st_res;
    transaction_id_next   = transaction_id;
    busy_next             = busy;
    pending_unit_next     = pending_unit;
    pending_function_next = pending_function;
    header_store_next     = header_store;
    first_data_byte_next  = first_data_byte;
    rx_count_next         = rx_count;
    delivered_count_next  = delivered_count;
    load        = 1'b0;
    load_hdr    = 1'b0;
    load_len    = '0;
    load_bytes  = '0;
    load_res[0] = '0;
    load_res[1] = '0;
    tid_new     = transaction_id + {15'd0, !din.repeat_id};
    cbytes      = {7'd0, din.payload_length} + 16'd2;
    st_res      = '0;
    if (accept) begin
      case (opcode_t'(din.opcode))
        OP_BEGIN: begin
          load = 1'b1;
          if (!server_mode && busy) begin
            load_res[0].kind   = KIND_STATUS;
            load_res[0].last   = 1'b1;
            load_res[0].status = ST_BUSY;
          end else begin
            if (server_mode) begin
              tid_new = transaction_id;
            end else begin
              transaction_id_next   = tid_new;
              pending_unit_next     = din.unit_id;
              pending_function_next = din.function_code;
              busy_next             = 1'b1;
            end
            if (din.payload_length > 9'(MAX_PAYLOAD)) begin
              load_res[0].kind   = KIND_STATUS;
              load_res[0].last   = 1'b1;
              load_res[0].status = ST_OVERFLOW;
            end else begin
              load_hdr      = 1'b1;
              load_len      = RUN_W'(HDR_BYTES - 1);
              load_bytes[0] = tid_new[15:8];
              load_bytes[1] = tid_new[7:0];
              load_bytes[2] = 8'd0;
              load_bytes[3] = 8'd0;
              load_bytes[4] = cbytes[15:8];
              load_bytes[5] = cbytes[7:0];
              load_bytes[6] = din.unit_id;
              load_bytes[7] = din.function_code;
            end
          end
        end
        OP_SEND: begin
          load                 = 1'b1;
          load_res[0].kind     = KIND_TX;
          load_res[0].byte_out = din.data_byte;
          load_res[0].last     = 1'b1;
        end
        OP_RECV: begin
          header_store_next    = rx_hdr;
          first_data_byte_next = rx_first;
          delivered_count_next = rx_dc;
          rx_count_next        = rx_cnt_new;
          load = rx_deliver || din.frame_end;
          if (rx_deliver) begin
            load_res[0].kind     = KIND_RX;
            load_res[0].byte_out = din.data_byte;
            load_res[0].last     = !din.frame_end;
          end
          if (din.frame_end) begin
            st_res.kind   = KIND_STATUS;
            st_res.last   = 1'b1;
            st_res.status = chk_out.status;
            st_res.exc    = chk_out.exc;
            st_res.cnt    = rx_dc;
            if (chk_out.status != ST_SHORT) begin
              st_res.ru = rx_hdr[6];
              st_res.rf = rx_hdr[7];
            end
            if (rx_deliver) begin
              load_res[1] = st_res;
              load_len    = RUN_W'(1);
            end else begin
              load_res[0] = st_res;
            end
            if (server_mode && chk_out.status == ST_GOOD) begin
              transaction_id_next = {rx_hdr[0], rx_hdr[1]};
            end
            busy_next            = 1'b0;
            rx_count_next        = '0;
            delivered_count_next = '0;
            first_data_byte_next = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      server_mode      <= 1'b0;
      max_read_length  <= 8'(MAX_PAYLOAD);
      transaction_id   <= '0;
      busy             <= 1'b0;
      pending_unit     <= '0;
      pending_function <= '0;
      first_data_byte  <= '0;
      rx_count         <= '0;
      delivered_count  <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_SERVER_MODE: server_mode     <= cfg_data[0];
          REG_MAX_READ:    max_read_length <= cfg_data;
          default: begin
          end
        endcase
      end
      transaction_id   <= transaction_id_next;
      busy             <= busy_next;
      pending_unit     <= pending_unit_next;
      pending_function <= pending_function_next;
      first_data_byte  <= first_data_byte_next;
      rx_count         <= rx_count_next;
      delivered_count  <= delivered_count_next;
    end
  end

  always_ff @(posedge clk) begin
    header_store <= header_store_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
      run_hdr   <= 1'b0;
      run_len   <= '0;
      run_idx   <= '0;
    end else if (accept && load) begin
      run_valid <= 1'b1;
      run_hdr   <= load_hdr;
      run_len   <= load_len;
      run_idx   <= '0;
    end else if (dout.valid && dout.ready) begin
      if (run_idx == run_len) begin
        run_valid <= 1'b0;
      end else begin
        run_idx <= run_idx + RUN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && load) begin
      run_bytes  <= load_bytes;
      run_res[0] <= load_res[0];
      run_res[1] <= load_res[1];
    end
  end

  always_comb begin
    if (run_hdr) begin
      cur          = '0;
      cur.kind     = KIND_TX;
      cur.byte_out = run_bytes[run_idx];
      cur.last     = (run_idx == run_len);
    end else begin
      cur = run_res[run_idx[0]];
    end
  end

  assign dout.valid          = run_valid;
  assign dout.kind           = cur.kind;
  assign dout.byte_out       = cur.byte_out;
  assign dout.last_of_run    = cur.last;
  assign dout.status         = cur.status;
  assign dout.exception_code = cur.exc;
  assign dout.resp_unit      = cur.ru;
  assign dout.resp_function  = cur.rf;
  assign dout.payload_count  = cur.cnt;

endmodule

### sim/mbap_checker.sv
// Scoreboard for the MBAP frame builder: predicts every result and compares it field by field.
`timescale 1ns / 1ps

module mbap_checker import mbap_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_data,
  mbap_in_if         din,
  mbap_out_if        dout,
  output int         fail_count,
  output int         due_count
);

  logic                server;
  logic [7:0]          max_read;
  logic [15:0]         tid;
  logic                busy;
  logic [7:0]          req_unit;
  logic [7:0]          req_func;
  logic [7:0]          rx_hdr [HDR_BYTES];
  logic [7:0]          first_pay;
  logic [RX_W-1:0]     rx_cnt;
  logic [7:0]          delivered;
  result_t             due_results [$];
  result_t             want;

  function automatic void add_due(kind_t k, logic [7:0] b, logic l, status_t s,
                                  logic [7:0] exc, logic [7:0] ru, logic [7:0] rf,
                                  logic [7:0] cnt);
    result_t r;
    r.kind     = k;
    r.byte_out = b;
    r.last     = l;
    r.status   = s;
    r.exc      = exc;
    r.ru       = ru;
    r.rf       = rf;
    r.cnt      = cnt;
    due_results.push_back(r);
  endfunction

  function automatic status_t frame_verdict(output logic [7:0] exc);
    logic [15:0] len_field;
    logic [15:0] rx_id;
    exc = 8'h00;
    if (rx_cnt < HDR_BYTES) return ST_SHORT;
    if (rx_hdr[2] != 8'h00 || rx_hdr[3] != 8'h00) return ST_PROTOCOL;
    len_field = {rx_hdr[4], rx_hdr[5]};
    rx_id     = {rx_hdr[0], rx_hdr[1]};
    if (rx_cnt >= RX_MAX || int'(len_field) != int'(rx_cnt) - PREFIX_BYTES) return ST_LENGTH;
    if (server) begin
      tid = rx_id;
      return ST_GOOD;
    end
    if (rx_id != tid) return ST_ID;
    if (rx_hdr[6] != req_unit) return ST_UNIT;
    if (rx_hdr[7][EXC_BIT]) begin
      if (rx_cnt > HDR_BYTES) begin
        exc = first_pay;
        return ST_EXCEPTION;
      end
      return ST_EXC_MISS;
    end
    if (rx_hdr[7] != req_func) return ST_FUNCTION;
    return ST_GOOD;
  endfunction

  function automatic void advance_mbap(logic [1:0] op, logic [7:0] unit, logic [7:0] func,
                                       logic [8:0] plen, logic rep, logic [7:0] data,
                                       logic fend);
    logic [7:0]  hb [HDR_BYTES];
    logic [15:0] field_len;
    logic [7:0]  exc;
    status_t     st;
    int          i;
    case (op)
      OP_BEGIN: begin
        if (!server) begin
          if (busy) begin
            add_due(KIND_STATUS, 8'h00, 1'b1, ST_BUSY, 8'h00, 8'h00, 8'h00, 8'h00);
            return;
          end
          if (!rep) tid = tid + 16'd1;
          req_unit = unit;
          req_func = func;
          busy     = 1'b1;
        end
        if (plen > MAX_PAYLOAD) begin
          add_due(KIND_STATUS, 8'h00, 1'b1, ST_OVERFLOW, 8'h00, 8'h00, 8'h00, 8'h00);
          return;
        end
        field_len = 16'(plen) + 16'd2;
        hb = '{tid[15:8], tid[7:0], 8'h00, 8'h00, field_len[15:8], field_len[7:0], unit, func};
        for (i = 0; i < HDR_BYTES; i++)
          add_due(KIND_TX, hb[i], i == HDR_BYTES - 1, ST_GOOD, 8'h00, 8'h00, 8'h00, 8'h00);
      end
      OP_SEND: add_due(KIND_TX, data, 1'b1, ST_GOOD, 8'h00, 8'h00, 8'h00, 8'h00);
      OP_RECV: begin
        if (rx_cnt < HDR_BYTES) begin
          rx_hdr[rx_cnt[2:0]] = data;
        end else begin
          if (rx_cnt == HDR_BYTES) first_pay = data;
          if (delivered < max_read) begin
            add_due(KIND_RX, data, !fend, ST_GOOD, 8'h00, 8'h00, 8'h00, 8'h00);
            delivered++;
          end
        end
        if (rx_cnt < RX_MAX) rx_cnt++;
        if (fend) begin
          st = frame_verdict(exc);
          add_due(KIND_STATUS, 8'h00, 1'b1, st, exc,
                  (st == ST_SHORT) ? 8'h00 : rx_hdr[6],
                  (st == ST_SHORT) ? 8'h00 : rx_hdr[7], delivered);
          busy      = 1'b0;
          rx_cnt    = '0;
          delivered = 8'h00;
          first_pay = 8'h00;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      server     = 1'b0;
      max_read   = 8'd252;
      tid        = '0;
      busy       = 1'b0;
      req_unit   = 8'h00;
      req_func   = 8'h00;
      first_pay  = 8'h00;
      rx_cnt     = '0;
      delivered  = 8'h00;
      fail_count = 0;
      due_results.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_SERVER_MODE: server = cfg_data[0];
          REG_MAX_READ:    max_read = cfg_data;
          default: ;
        endcase
      end
      if (dout.valid && dout.ready) begin
        if (due_results.size() == 0) begin
          fail_count++;
          $display("%0t: result with none expected, actual kind %0h byte %0h status %0h",
                   $time, dout.kind, dout.byte_out, dout.status);
        end else begin
          want = due_results.pop_front();
          check_field("kind", want.kind, dout.kind);
          check_field("byte_out", want.byte_out, dout.byte_out);
          check_field("last_of_run", want.last, dout.last_of_run);
          check_field("status", want.status, dout.status);
          check_field("exception_code", want.exc, dout.exception_code);
          check_field("resp_unit", want.ru, dout.resp_unit);
          check_field("resp_function", want.rf, dout.resp_function);
          check_field("payload_count", want.cnt, dout.payload_count);
        end
      end
      if (din.valid && din.ready)
        advance_mbap(din.opcode, din.unit_id, din.function_code, din.payload_length,
                     din.repeat_id, din.data_byte, din.frame_end);
    end
    due_count = due_results.size();
  end

endmodule

### sim/tb_top.sv
// Top-level testbench: clock, reset, configuration, stimulus and the final verdict.
`timescale 1ns / 1ps

module tb_top;
  import mbap_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int         HOLD_CYCLES = 300;
  localparam int         PHASE_ITEMS = 40;
  localparam int         LONG_PAYLOAD = 40;

  logic       clk;
  logic       rst;
  logic       cfg_write;
  logic [0:0] cfg_index;
  logic [7:0] cfg_data;

  int          fail_count;
  int          due_count;
  int          send_idle;
  int          recv_stall;
  int          items_sent;
  int          hold_left;
  bit          hold_req;
  logic [15:0] tid_m;
  bit          busy_m;
  bit          server_m;

  mbap_in_if  in_ch ();
  mbap_out_if out_ch ();

  mbap_frame_builder_checker u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .din       (in_ch),
    .dout      (out_ch)
  );

  mbap_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .din        (in_ch),
    .dout       (out_ch),
    .fail_count (fail_count),
    .due_count  (due_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic push(input logic [1:0] op, input logic [7:0] unit, input logic [7:0] func,
                      input logic [8:0] plen, input logic rep, input logic [7:0] data,
                      input logic fend);
    while ($urandom_range(0, 99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.opcode         <= op;
    in_ch.unit_id        <= unit;
    in_ch.function_code  <= func;
    in_ch.payload_length <= plen;
    in_ch.repeat_id      <= rep;
    in_ch.data_byte      <= data;
    in_ch.frame_end      <= fend;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (op != OP_UNUSED) items_sent++;
  endtask

  task automatic begin_req(input logic [7:0] unit, input logic [7:0] func,
                           input logic [8:0] plen, input logic rep);
    push(OP_BEGIN, unit, func, plen, rep, 8'($urandom), 1'($urandom));
    if (!server_m && !busy_m) begin
      if (!rep) tid_m++;
      busy_m = 1'b1;
    end
  endtask

  task automatic send_bytes(input int n);
    repeat (n)
      push(OP_SEND, 8'($urandom), 8'($urandom), 9'($urandom), 1'($urandom),
           8'($urandom), 1'($urandom));
  endtask

  // cut > 0 stops the frame early after that many bytes
  task automatic receive_frame(input logic [15:0] id, input logic [15:0] proto,
                               input logic [7:0] unit, input logic [7:0] func,
                               input int n, input int len_delta, input int cut);
    logic [7:0]  fr [$];
    logic [15:0] len;
    int          total;
    int          i;
    len = 16'(n + 2 + len_delta);
    fr = '{id[15:8], id[7:0], proto[15:8], proto[7:0], len[15:8], len[7:0], unit, func};
    repeat (n) fr.push_back(8'($urandom));
    total = (cut > 0 && cut < fr.size()) ? cut : fr.size();
    for (i = 0; i < total; i++)
      push(OP_RECV, 8'($urandom), 8'($urandom), 9'($urandom), 1'($urandom),
           fr[i], i == total - 1);
    if (server_m && total >= HDR_BYTES && total < RX_MAX && proto == 16'h0000 &&
        int'(len) == total - PREFIX_BYTES)
      tid_m = id;
    busy_m = 1'b0;
  endtask

  task automatic client_exchange();
    logic [7:0] unit;
    logic [7:0] func;
    logic [8:0] plen;
    int         n;
    int         delta;
    unit  = 8'($urandom);
    func  = 8'($urandom_range(1, 127));
    plen  = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(253, 511)) : 9'($urandom_range(0, 6));
    n     = $urandom_range(0, 6);
    delta = ($urandom_range(0, 1) != 0) ? int'($urandom_range(1, 300))
                                        : -int'($urandom_range(1, 2));
    begin_req(unit, func, plen, $urandom_range(0, 7) == 0);
    if ($urandom_range(0, 5) == 0)
      begin_req(8'($urandom), 8'($urandom), 9'($urandom), 1'($urandom));
    if (plen <= MAX_PAYLOAD) send_bytes(int'(plen));
    case ($urandom_range(0, 11))
      5:  receive_frame(tid_m, 16'($urandom_range(1, 65535)), unit, func, n, 0, 0);
      6:  receive_frame(tid_m, 16'h0000, unit, func, n, delta, 0);
      7:  receive_frame(tid_m + 16'($urandom_range(1, 65535)), 16'h0000, unit, func, n, 0, 0);
      8:  receive_frame(tid_m, 16'h0000, unit ^ 8'($urandom_range(1, 255)), func, n, 0, 0);
      9:  receive_frame(tid_m, 16'h0000, unit, func | 8'h80, n, 0, 0);
      10: receive_frame(tid_m, 16'h0000, unit, func ^ 8'($urandom_range(1, 127)), n, 0, 0);
      11: receive_frame(tid_m, 16'h0000, unit, func, n, 0, $urandom_range(1, 7));
      default: receive_frame(tid_m, 16'h0000, unit, func, n, 0, 0);
    endcase
  endtask

  task automatic server_exchange();
    logic [7:0] unit;
    logic [7:0] func;
    logic [8:0] plen;
    int         n;
    unit = 8'($urandom);
    func = 8'($urandom);
    plen = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(253, 511)) : 9'($urandom_range(0, 6));
    n    = $urandom_range(0, 6);
    case ($urandom_range(0, 8))
      6: receive_frame(16'($urandom), 16'($urandom_range(1, 65535)), unit, func, n, 0, 0);
      7: receive_frame(16'($urandom), 16'h0000, unit, func, n, int'($urandom_range(1, 40)), 0);
      8: receive_frame(16'($urandom), 16'h0000, unit, func, n, 0, $urandom_range(1, 7));
      default: receive_frame(16'($urandom), 16'h0000, unit, func, n, 0, 0);
    endcase
    begin_req(unit, func, plen, 1'($urandom));
    if (plen <= MAX_PAYLOAD) send_bytes(int'(plen));
  endtask

  task automatic random_traffic(input int n);
    int goal;
    goal = items_sent + n;
    while (items_sent < goal) begin
      case ($urandom_range(0, 9))
        0: push(OP_UNUSED, 8'($urandom), 8'($urandom), 9'($urandom), 1'($urandom),
                8'($urandom), 1'($urandom));
        1: receive_frame(16'($urandom), 16'($urandom_range(0, 1)), 8'($urandom), 8'($urandom),
                         $urandom_range(0, 4), int'($urandom_range(0, 2)),
                         $urandom_range(0, 12));
        2: send_bytes($urandom_range(1, 2));
        default: begin
          if (server_m) server_exchange();
          else client_exchange();
        end
      endcase
    end
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_config(input logic srv, input logic [7:0] max_read);
    cfg_write <= 1'b1;
    cfg_index <= REG_SERVER_MODE;
    cfg_data  <= {7'd0, srv};
    @(posedge clk);
    cfg_index <= REG_MAX_READ;
    cfg_data  <= max_read;
    @(posedge clk);
    cfg_write <= 1'b0;
    server_m = srv;
  endtask

  initial begin
    out_ch.ready = 1'b0;
    hold_left    = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_stall);
      end
    end
  end

  initial begin
    rst                  = 1'b1;
    cfg_write            = 1'b0;
    cfg_index            = REG_SERVER_MODE;
    cfg_data             = 8'h00;
    in_ch.valid          = 1'b0;
    in_ch.opcode         = OP_BEGIN;
    in_ch.unit_id        = 8'h00;
    in_ch.function_code  = 8'h00;
    in_ch.payload_length = 9'h000;
    in_ch.repeat_id      = 1'b0;
    in_ch.data_byte      = 8'h00;
    in_ch.frame_end      = 1'b0;
    send_idle            = 0;
    recv_stall           = 0;
    items_sent           = 0;
    hold_req             = 1'b0;
    tid_m                = 16'h0000;
    busy_m               = 1'b0;
    server_m             = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    set_config(1'b0, 8'd252);
    begin_req(8'h00, 8'h00, 9'd0, 1'b0);
    begin_req(8'hFF, 8'hFF, 9'h1FF, 1'b1);
    push(OP_SEND, 8'h00, 8'h00, 9'h000, 1'b0, 8'h00, 1'b0);
    push(OP_SEND, 8'hFF, 8'hFF, 9'h1FF, 1'b1, 8'hFF, 1'b1);
    receive_frame(tid_m, 16'h0000, 8'h00, 8'h80, 0, 0, 0);
    push(OP_UNUSED, 8'hFF, 8'hFF, 9'h1FF, 1'b1, 8'hFF, 1'b1);
    begin_req(8'h5A, 8'h03, 9'd253, 1'b1);
    receive_frame(tid_m, 16'h0000, 8'h5A, 8'h03, 0, 0, 3);
    begin_req(8'hFF, 8'hFF, 9'd252, 1'b0);
    send_bytes(2);
    receive_frame(tid_m, 16'h0000, 8'hFF, 8'hFF, 1, 0, 0);

    hold_req = 1'b1;
    random_traffic(PHASE_ITEMS);
    settle();

    set_config(1'b1, 8'd0);
    send_idle  = 88;
    recv_stall = 0;
    random_traffic(PHASE_ITEMS);
    settle();

    set_config(1'b0, 8'd3);
    send_idle  = 0;
    recv_stall = 88;
    random_traffic(PHASE_ITEMS);
    settle();

    set_config(1'b1, 8'd252);
    send_idle  = 8;
    recv_stall = 8;
    receive_frame(16'h1234, 16'h0000, 8'h11, 8'h22, LONG_PAYLOAD, 0, 0);
    random_traffic(PHASE_ITEMS);
    settle();

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### mbap_frame_builder_checker.f
rtl/mbap_pkg.sv
rtl/mbap_if.sv
rtl/mbap_check.sv
rtl/mbap_frame_builder_checker.sv
sim/mbap_checker.sv
sim/tb_top.sv
